@@ hw/rtl/marching_squares_contour_core_macros.svh @@
// Assertion macros for the marching squares contour core.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef MARCHING_SQUARES_CONTOUR_CORE_MACROS_SVH
`define MARCHING_SQUARES_CONTOUR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/msc_pkg.sv @@
// Shared types, register indexes and the segment table of the contour core.
// No dependencies.
package msc_pkg;

    localparam int COORD_W = 19;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GW_REG_W = 11;
    localparam int ISO_W = 16;
    localparam int ROW_W = 10;
    localparam int HEIGHT_LIMIT = 1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL   = 2'd2;

    // Edge crossing points; the code doubles as the edge index.
    localparam logic [1:0] PT_B = 2'd0;
    localparam logic [1:0] PT_R = 2'd1;
    localparam logic [1:0] PT_T = 2'd2;
    localparam logic [1:0] PT_L = 2'd3;

    typedef struct packed {
        logic [1:0] count;
        logic [1:0] p0;
        logic [1:0] q0;
        logic [1:0] p1;
        logic [1:0] q1;
    } seg_plan_t;

    function automatic seg_plan_t seg_lookup(input logic [3:0] code, input logic ctr);
        seg_plan_t r;
        r = '{count: 2'd0, p0: PT_L, q0: PT_B, p1: PT_T, q1: PT_R};
        case (code) inside
            4'd1, 4'd14: r = '{2'd1, PT_L, PT_B, PT_L, PT_B};
            4'd2, 4'd13: r = '{2'd1, PT_B, PT_R, PT_B, PT_R};
            4'd3, 4'd12: r = '{2'd1, PT_L, PT_R, PT_L, PT_R};
            4'd4, 4'd11: r = '{2'd1, PT_R, PT_T, PT_R, PT_T};
            4'd6, 4'd9:  r = '{2'd1, PT_B, PT_T, PT_B, PT_T};
            4'd7, 4'd8:  r = '{2'd1, PT_L, PT_T, PT_L, PT_T};
            4'd5: begin
                if (ctr) r = '{2'd2, PT_L, PT_T, PT_B, PT_R};
                else     r = '{2'd2, PT_L, PT_B, PT_T, PT_R};
            end
            4'd10: begin
                if (ctr) r = '{2'd2, PT_L, PT_B, PT_T, PT_R};
                else     r = '{2'd2, PT_L, PT_T, PT_B, PT_R};
            end
            default: r.count = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/marching_squares_contour_core.sv @@
// Marching squares contour core: line buffer memory, cell classifier and a shared
// bit-serial divider for the edge crossings. Uses msc_pkg and the macros header.
// Per sample: idle and read, a line buffer write at a row end, and classify once a cell
// is complete; a cell with segments adds edge setup, a bit-serial division per divided
// edge and a load and output wait per segment. A new sample waits until this is done.
// Reset (synchronous, aresetn low) clears counters, previous sample and iso level, and sets width and height to 1024.
`include "marching_squares_contour_core_macros.svh"

module marching_squares_contour_core #(
    parameter int MAX_GRID_WIDTH = 1024,
    parameter int FRACTION_BITS = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // start_x, start_y, end_x, end_y
    output logic [((4*msc_pkg::COORD_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [msc_pkg::CFG_W-1:0]              cfg_wdata
);

    localparam int CW = (MAX_GRID_WIDTH > 2) ? $clog2(MAX_GRID_WIDTH) : 1;
    localparam int WV = (CW + 1 > msc_pkg::GW_REG_W) ? CW + 1 : msc_pkg::GW_REG_W;
    localparam int SW = (SAMPLE_BITS > msc_pkg::ISO_W) ? SAMPLE_BITS : msc_pkg::ISO_W;
    localparam int DW = SW + 1;
    localparam int RW = DW + 1;
    localparam int SUMW = SW + 3;
    localparam int TW = FRACTION_BITS + 1;
    localparam int BCW = (FRACTION_BITS > 2) ? $clog2(FRACTION_BITS) : 1;
    localparam int XW = CW + FRACTION_BITS;
    localparam int YW = msc_pkg::ROW_W + FRACTION_BITS;
    localparam int OUT_W = ((4 * msc_pkg::COORD_W + 7) / 8) * 8;
    localparam int C = msc_pkg::COORD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_WR2   = 4'd2;
    localparam logic [3:0] S_CLASS = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;

    typedef logic [C-1:0] coord_t;

    logic [3:0] state_reg;

    // Configuration.
    logic [msc_pkg::GW_REG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic signed [msc_pkg::ISO_W-1:0] iso_reg;

    // Line buffer.
    logic [SAMPLE_BITS-1:0] row_mem [MAX_GRID_WIDTH];
    logic [SAMPLE_BITS-1:0] mem_rdata_reg;
    logic mem_we;
    logic [CW-1:0] mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    logic [CW-1:0] col_reg, col_cur_reg;
    logic [msc_pkg::ROW_W-1:0] row_reg, row_cur_reg;
    logic [CW-1:0] gx_reg;
    logic [msc_pkg::ROW_W-1:0] gy_reg;
    logic cell_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg, sample_reg, br_hold_reg;
    logic signed [SAMPLE_BITS-1:0] c_bl_reg, c_br_reg, c_tl_reg, c_tr_reg;

    msc_pkg::seg_plan_t plan_reg;
    logic [1:0] edge_reg;
    logic seg_idx_reg;
    logic [TW-1:0] t_b_reg, t_r_reg, t_t_reg, t_l_reg;

    logic [RW-1:0] div_rem_reg, div_den_reg;
    logic [FRACTION_BITS-1:0] div_q_reg;
    logic [BCW-1:0] div_cnt_reg;

    logic m_valid_reg, m_last_reg;
    coord_t sx_reg, sy_reg, ex_reg, ey_reg;

    // Effective sizes.
    logic [WV-1:0] w_raw, w_eff, w_last;
    logic [msc_pkg::GW_REG_W-1:0] h_eff;
    logic [CW-1:0] col_w;
    logic [msc_pkg::ROW_W-1:0] row_w;
    logic wrap;
    logic s_accept;

    always_comb begin
        w_raw = WV'(width_cfg_reg);
        if (w_raw < WV'(2))
            w_eff = WV'(2);
        else if (w_raw > WV'(MAX_GRID_WIDTH))
            w_eff = WV'(MAX_GRID_WIDTH);
        else
            w_eff = w_raw;
        w_last = w_eff - WV'(1);
        if (height_cfg_reg < msc_pkg::GW_REG_W'(2))
            h_eff = msc_pkg::GW_REG_W'(2);
        else if (height_cfg_reg > msc_pkg::GW_REG_W'(msc_pkg::HEIGHT_LIMIT))
            h_eff = msc_pkg::GW_REG_W'(msc_pkg::HEIGHT_LIMIT);
        else
            h_eff = height_cfg_reg;
        wrap = (WV'(col_reg) >= w_eff)
            || (msc_pkg::GW_REG_W'(row_reg) >= h_eff);
        col_w = wrap ? '0 : col_reg;
        row_w = wrap ? '0 : row_reg;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Classification of the current cell.
    logic signed [SW-1:0] iso_x;
    logic [3:0] case_code;
    logic signed [SUMW-1:0] corner_sum, iso_x4;
    logic center_in;
    msc_pkg::seg_plan_t plan_next;

    always_comb begin
        iso_x = SW'(iso_reg);
        case_code[0] = SW'(c_bl_reg) >= iso_x;
        case_code[1] = SW'(c_br_reg) >= iso_x;
        case_code[2] = SW'(c_tr_reg) >= iso_x;
        case_code[3] = SW'(c_tl_reg) >= iso_x;
        corner_sum = SUMW'(c_bl_reg) + SUMW'(c_br_reg) + SUMW'(c_tr_reg) + SUMW'(c_tl_reg);
        iso_x4 = SUMW'(iso_x) <<< 2;
        center_in = corner_sum >= iso_x4;
        plan_next = msc_pkg::seg_lookup(case_code, center_in);
    end

    // Edge setup: handles the trivial crossings and prepares the divider.
    logic signed [SAMPLE_BITS-1:0] ea, eb;
    logic signed [DW-1:0] num_s, den_s, num_n, den_n;
    logic setup_direct;
    logic [TW-1:0] setup_t;

    always_comb begin
        case (edge_reg)
            msc_pkg::PT_B: begin ea = c_bl_reg; eb = c_br_reg; end
            msc_pkg::PT_R: begin ea = c_br_reg; eb = c_tr_reg; end
            msc_pkg::PT_T: begin ea = c_tl_reg; eb = c_tr_reg; end
            default:       begin ea = c_bl_reg; eb = c_tl_reg; end
        endcase
        num_s = DW'(iso_x) - DW'(ea);
        den_s = DW'(eb) - DW'(ea);
        if (den_s < 0) begin
            num_n = -num_s;
            den_n = -den_s;
        end else begin
            num_n = num_s;
            den_n = den_s;
        end
        setup_direct = 1'b1;
        setup_t = '0;
        if (den_s == '0)
            setup_t = TW'(1) << (FRACTION_BITS - 1);
        else if (num_n <= 0)
            setup_t = '0;
        else if (num_n >= den_n)
            setup_t = TW'(1) << FRACTION_BITS;
        else
            setup_direct = 1'b0;
    end

    // One restoring division step.
    logic [RW-1:0] rem_shift;
    logic rem_ge;
    logic [FRACTION_BITS-1:0] q_next;

    always_comb begin
        rem_shift = div_rem_reg << 1;
        rem_ge = rem_shift >= div_den_reg;
        q_next = {div_q_reg[FRACTION_BITS-2:0], rem_ge};
    end

    // Segment endpoints from the four crossings.
    coord_t x0, y0, one, sel_px, sel_py, sel_qx, sel_qy;
    logic [1:0] sel_p, sel_q;

    function automatic coord_t pick_x(input logic [1:0] pt, input coord_t bx,
                                      input coord_t rx, input coord_t tx, input coord_t lx);
        coord_t r;
        case (pt)
            msc_pkg::PT_B: r = bx;
            msc_pkg::PT_R: r = rx;
            msc_pkg::PT_T: r = tx;
            default:       r = lx;
        endcase
        return r;
    endfunction

    coord_t bx, by, rx, ry, tx, ty, lx, ly;

    always_comb begin
        x0 = C'(XW'(gx_reg) << FRACTION_BITS);
        y0 = C'(YW'(gy_reg) << FRACTION_BITS);
        one = C'(1) << FRACTION_BITS;
        bx = x0 + C'(t_b_reg);  by = y0;
        rx = x0 + one;          ry = y0 + C'(t_r_reg);
        tx = x0 + C'(t_t_reg);  ty = y0 + one;
        lx = x0;                ly = y0 + C'(t_l_reg);
        sel_p = seg_idx_reg ? plan_reg.p1 : plan_reg.p0;
        sel_q = seg_idx_reg ? plan_reg.q1 : plan_reg.q0;
        sel_px = pick_x(sel_p, bx, rx, tx, lx);
        sel_py = pick_x(sel_p, by, ry, ty, ly);
        sel_qx = pick_x(sel_q, bx, rx, tx, lx);
        sel_qy = pick_x(sel_q, by, ry, ty, ly);
    end

    // Line buffer writes: the previous sample in the read cycle, the row's last
    // sample in the extra cycle at the end of a row.
    always_comb begin
        mem_we = 1'b0;
        mem_waddr = col_cur_reg - CW'(1);
        mem_wdata = prev_reg;
        if (state_reg == S_READ && col_cur_reg != '0)
            mem_we = 1'b1;
        if (state_reg == S_WR2) begin
            mem_we = 1'b1;
            mem_waddr = col_cur_reg;
            mem_wdata = sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we)
            row_mem[mem_waddr] <= mem_wdata;
        if (s_accept)
            mem_rdata_reg <= row_mem[col_w];
    end

    logic [TW-1:0] t_store;
    logic t_store_en;

    always_comb begin
        t_store_en = 1'b0;
        t_store = setup_t;
        if (state_reg == S_SETUP && setup_direct)
            t_store_en = 1'b1;
        if (state_reg == S_DIV && div_cnt_reg == BCW'(FRACTION_BITS - 1)) begin
            t_store_en = 1'b1;
            t_store = TW'(q_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            width_cfg_reg <= msc_pkg::GW_REG_W'(1024);
            height_cfg_reg <= msc_pkg::GW_REG_W'(1024);
            iso_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            prev_reg <= '0;
            m_valid_reg <= 1'b0;
            seg_idx_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    msc_pkg::REG_GRID_WIDTH:
                        width_cfg_reg <= cfg_wdata[msc_pkg::GW_REG_W-1:0];
                    msc_pkg::REG_GRID_HEIGHT:
                        height_cfg_reg <= cfg_wdata[msc_pkg::GW_REG_W-1:0];
                    msc_pkg::REG_ISO_LEVEL:
                        iso_reg <= cfg_wdata[msc_pkg::ISO_W-1:0];
                    default: ;
                endcase
            end
            if (t_store_en) begin
                case (edge_reg)
                    msc_pkg::PT_B: t_b_reg <= t_store;
                    msc_pkg::PT_R: t_r_reg <= t_store;
                    msc_pkg::PT_T: t_t_reg <= t_store;
                    default:       t_l_reg <= t_store;
                endcase
                edge_reg <= edge_reg + 2'd1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        col_cur_reg <= col_w;
                        row_cur_reg <= row_w;
                        sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    c_bl_reg <= br_hold_reg;
                    c_br_reg <= mem_rdata_reg;
                    br_hold_reg <= mem_rdata_reg;
                    c_tl_reg <= prev_reg;
                    c_tr_reg <= sample_reg;
                    prev_reg <= sample_reg;
                    gx_reg <= col_cur_reg - CW'(1);
                    gy_reg <= row_cur_reg - msc_pkg::ROW_W'(1);
                    cell_reg <= (col_cur_reg != '0) && (row_cur_reg != '0);
                    if (WV'(col_cur_reg) == w_last) begin
                        col_reg <= '0;
                        if (msc_pkg::GW_REG_W'(row_cur_reg) == h_eff - msc_pkg::GW_REG_W'(1))
                            row_reg <= '0;
                        else
                            row_reg <= row_cur_reg + msc_pkg::ROW_W'(1);
                        state_reg <= S_WR2;
                    end else begin
                        col_reg <= col_cur_reg + CW'(1);
                        row_reg <= row_cur_reg;
                        if ((col_cur_reg != '0) && (row_cur_reg != '0))
                            state_reg <= S_CLASS;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_WR2: begin
                    state_reg <= cell_reg ? S_CLASS : S_IDLE;
                end
                S_CLASS: begin
                    plan_reg <= plan_next;
                    edge_reg <= 2'd0;
                    seg_idx_reg <= 1'b0;
                    state_reg <= (plan_next.count == 2'd0) ? S_IDLE : S_SETUP;
                end
                S_SETUP: begin
                    if (setup_direct) begin
                        if (edge_reg == msc_pkg::PT_L)
                            state_reg <= S_LOAD;
                    end else begin
                        div_rem_reg <= RW'(unsigned'(num_n));
                        div_den_reg <= RW'(unsigned'(den_n));
                        div_q_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    div_rem_reg <= rem_ge ? rem_shift - div_den_reg : rem_shift;
                    div_q_reg <= q_next;
                    div_cnt_reg <= div_cnt_reg + BCW'(1);
                    if (div_cnt_reg == BCW'(FRACTION_BITS - 1))
                        state_reg <= (edge_reg == msc_pkg::PT_L) ? S_LOAD : S_SETUP;
                end
                S_LOAD: begin
                    sx_reg <= sel_px;
                    sy_reg <= sel_py;
                    ex_reg <= sel_qx;
                    ey_reg <= sel_qy;
                    m_last_reg <= seg_idx_reg || (plan_reg.count == 2'd1);
                    m_valid_reg <= 1'b1;
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_axis_tready) begin
                        m_valid_reg <= 1'b0;
                        if (!seg_idx_reg && plan_reg.count == 2'd2) begin
                            seg_idx_reg <= 1'b1;
                            state_reg <= S_LOAD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast = m_last_reg;
    assign m_axis_tdata = OUT_W'({ey_reg, ex_reg, sy_reg, sx_reg});

    `MSC_ASSERT_IMPLY(a_valid_only_in_wait, m_valid_reg, state_reg == S_WAIT)
    `MSC_ASSERT_NEXT(a_accept_reads, s_accept, state_reg == S_READ)
    `MSC_ASSERT_IMPLY(a_div_rem_below_den, state_reg == S_DIV, div_rem_reg < div_den_reg)
    `MSC_ASSERT_IMPLY(a_second_seg_planned, state_reg == S_LOAD && seg_idx_reg,
                      plan_reg.count == 2'd2)

endmodule
